FILE: src/atd_pkg.sv
// ----------------------------------------------------------------------------
// atd_pkg: shared types and constants for the accelerometer tap detector
// Sample and result word layouts, register indexes and register reset values.
// ----------------------------------------------------------------------------
package atd_pkg;

	localparam int unsigned AXIS_W   = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned JERK_W   = 18;
	localparam int unsigned MS_W     = 16;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 18;

	// register reset values
	localparam logic              ENABLE_RST    = 1'b1;
	localparam logic [JERK_W-1:0] THRESHOLD_RST = 18'd1200;
	localparam logic [MS_W-1:0]   REFRACT_RST   = 16'd400;
	localparam logic [MS_W-1:0]   SETTLE_RST    = 16'd750;

	// register indexes on the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE     = 8'd0,
		CFG_THRESHOLD  = 8'd1,
		CFG_REFRACTORY = 8'd2,
		CFG_SETTLE     = 8'd3
	} atd_cfg_idx_t;

	// one input word: three axis readings and a timestamp
	typedef struct packed {
		logic signed [AXIS_W-1:0] accel_x;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] accel_z;
		logic [TIME_W-1:0]        time_ms;
	} atd_sample_t;

	// one result word
	typedef struct packed {
		logic              tap;
		logic [JERK_W-1:0] jerk;
	} atd_result_t;

endpackage

FILE: src/accel_tap_detector.sv
// ----------------------------------------------------------------------------
// accel_tap_detector: jerk-threshold tap detection on a 3-axis sample stream
// Sums absolute per-axis change between samples and flags a tap when the
// sum reaches the threshold while enabled, outside the settle and refractory windows.
// ----------------------------------------------------------------------------
// A sample accepted into the input register moves into the result register once the result side is free.
// Throughput: one sample per cycle unless the result side stalls; one input register feeds
// one result register, and when enabled the detector state updates as each word moves on.
// Reset: config registers take their default values (enabled, threshold 1200,
// refractory 400 ms, settle 750 ms); history and tap state clear at once.
module accel_tap_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample channel
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  atd_pkg::atd_sample_t              sample,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output atd_pkg::atd_result_t              result,
	// config write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [atd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [atd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import atd_pkg::*;

	// absolute difference of two signed axis readings; always fits AXIS_W bits
	function automatic logic [AXIS_W-1:0] abs_diff(
		input logic signed [AXIS_W-1:0] a,
		input logic signed [AXIS_W-1:0] b
	);
		logic signed [AXIS_W:0] d;
		logic        [AXIS_W:0] m;
		begin
			d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
			m = d[AXIS_W] ? (~d + 1'b1) : d;
			return m[AXIS_W-1:0];
		end
	endfunction

	// config registers
	logic              enable_q;
	logic [JERK_W-1:0] threshold_q;
	logic [MS_W-1:0]   refract_q;
	logic [MS_W-1:0]   settle_q;

	// detector history
	logic signed [AXIS_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic                     have_prev_q;
	logic [TIME_W-1:0]        settle_start_q;
	logic [TIME_W-1:0]        last_tap_q;
	logic                     tap_seen_q;

	// input stage and result stage
	atd_sample_t sample_s1;
	logic        valid_s1;
	atd_result_t result_q;
	logic        result_valid_q;

	logic        out_free;
	logic        advance;
	logic        take;

	logic [AXIS_W-1:0] dx, dy, dz;
	logic [JERK_W-1:0] jerk_sum;
	logic [JERK_W-1:0] jerk_c;
	logic [TIME_W-1:0] settle_base;
	logic [TIME_W-1:0] settle_elapsed;
	logic [TIME_W-1:0] since_tap;
	logic              settling;
	logic              blocked;
	logic              tap_c;

	// handshake
	assign out_free     = !result_valid_q || !result_stall;
	assign advance      = valid_s1 && out_free;
	assign take         = sample_valid && !sample_stall;
	assign sample_stall = valid_s1 && !out_free;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// jerk from the stage-1 sample against the held history
	always_comb begin
		dx       = abs_diff(sample_s1.accel_x, prev_x_q);
		dy       = abs_diff(sample_s1.accel_y, prev_y_q);
		dz       = abs_diff(sample_s1.accel_z, prev_z_q);
		jerk_sum = JERK_W'(dx) + JERK_W'(dy) + JERK_W'(dz);
		jerk_c   = have_prev_q ? jerk_sum : '0;
	end

	// settle and refractory windows, wrap-safe
	always_comb begin
		settle_base    = have_prev_q ? settle_start_q : sample_s1.time_ms;
		settle_elapsed = sample_s1.time_ms - settle_base - TIME_W'(settle_q);
		settling       = settle_elapsed[TIME_W-1];
		since_tap      = sample_s1.time_ms - last_tap_q;
		blocked        = tap_seen_q && (since_tap < TIME_W'(refract_q));
		tap_c          = enable_q && !settling && (jerk_c >= threshold_q) && !blocked;
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= ENABLE_RST;
			threshold_q <= THRESHOLD_RST;
			refract_q   <= REFRACT_RST;
			settle_q    <= SETTLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLE:     enable_q    <= cfg_data[0];
				CFG_THRESHOLD:  threshold_q <= cfg_data[JERK_W-1:0];
				CFG_REFRACTORY: refract_q   <= cfg_data[MS_W-1:0];
				CFG_SETTLE:     settle_q    <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage-1 valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
		end
		if (advance) begin
			result_q.tap  <= tap_c;
			result_q.jerk <= enable_q ? jerk_c : '0;
		end
	end

	// history update; a disabled block leaves it untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			prev_z_q       <= '0;
			have_prev_q    <= 1'b0;
			settle_start_q <= '0;
			last_tap_q     <= '0;
			tap_seen_q     <= 1'b0;
		end else if (advance && enable_q) begin
			prev_x_q    <= sample_s1.accel_x;
			prev_y_q    <= sample_s1.accel_y;
			prev_z_q    <= sample_s1.accel_z;
			have_prev_q <= 1'b1;
			if (!have_prev_q) begin
				settle_start_q <= sample_s1.time_ms;
			end
			if (tap_c) begin
				last_tap_q <= sample_s1.time_ms;
				tap_seen_q <= 1'b1;
			end
		end
	end

endmodule

FILE: src/atd_checker.sv
// ----------------------------------------------------------------------------
// atd_checker: port-level checks for the accelerometer tap detector
// Watches the sample and result channels over time.
// ----------------------------------------------------------------------------
module atd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	input  logic                              sample_stall,
	input  logic                              result_valid,
	input  logic                              result_stall,
	input  atd_pkg::atd_result_t              result
);
	import atd_pkg::*;

	// an empty result register never backs up the sample side
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("sample stalled while result register empty");

	// while the result side stays open, a taken word moves on from the input register to the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall && !result_stall) ##1 !result_stall |=> result_valid)
		else $error("accepted word did not reach the result register");

	// a stalled result word stays valid
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("result word dropped while stalled");

	// a stalled result word holds its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(result))
		else $error("result payload changed while stalled");

endmodule

bind accel_tap_detector atd_checker u_atd_checker (.*);

FILE: tb/atd_tap_checker.sv
// ----------------------------------------------------------------------------
// atd_tap_checker: result checker for the accelerometer tap detector
// Watches the sample, result and config channels, keeps its own model of the
// jerk and tap-window logic, and compares every result word in order.
// ----------------------------------------------------------------------------
module atd_tap_checker
	import atd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_stall,
	input  atd_sample_t           sample,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  atd_result_t           result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           mismatches,
	output int unsigned           pending
);

	// register copies
	logic              en_q;
	logic [JERK_W-1:0] thresh_q;
	logic [MS_W-1:0]   refract_q;
	logic [MS_W-1:0]   settle_q;

	// detector history
	logic signed [AXIS_W-1:0] last_x, last_y, last_z;
	logic                     have_last;
	logic [TIME_W-1:0]        settle_from;
	logic [TIME_W-1:0]        last_tap_ms;
	logic                     tapped;

	atd_result_t expected_words[$];

	initial mismatches = 0;
	initial pending = 0;

	function automatic int unsigned axis_delta(logic signed [AXIS_W-1:0] a,
		logic signed [AXIS_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	// works out the result word for one sample and, when enabled, advances the history
	function automatic atd_result_t predict_tap(atd_sample_t s);
		atd_result_t       r;
		int unsigned       sum;
		logic [TIME_W-1:0] ready_at;
		logic [TIME_W-1:0] past_ready;
		logic [TIME_W-1:0] since_tap;
		logic              blocked;
		r = '0;
		if (!en_q) begin
			return r;
		end
		sum = 0;
		if (have_last) begin
			sum = axis_delta(s.accel_x, last_x) + axis_delta(s.accel_y, last_y)
				+ axis_delta(s.accel_z, last_z);
		end else begin
			settle_from = s.time_ms;
		end
		last_x = s.accel_x;
		last_y = s.accel_y;
		last_z = s.accel_z;
		have_last = 1'b1;
		r.jerk = sum[JERK_W-1:0];
		// settle window: signed distance from the end of the window
		ready_at   = settle_from + {{(TIME_W-MS_W){1'b0}}, settle_q};
		past_ready = s.time_ms - ready_at;
		if (!past_ready[TIME_W-1] && sum >= int'(thresh_q)) begin
			since_tap = s.time_ms - last_tap_ms;
			blocked   = tapped && (since_tap < {{(TIME_W-MS_W){1'b0}}, refract_q});
			if (!blocked) begin
				r.tap       = 1'b1;
				last_tap_ms = s.time_ms;
				tapped      = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		atd_result_t exp_word;
		if (!arst_n) begin
			en_q        = ENABLE_RST;
			thresh_q    = THRESHOLD_RST;
			refract_q   = REFRACT_RST;
			settle_q    = SETTLE_RST;
			last_x      = '0;
			last_y      = '0;
			last_z      = '0;
			have_last   = 1'b0;
			settle_from = '0;
			last_tap_ms = '0;
			tapped      = 1'b0;
			expected_words.delete();
		end else begin
			// sample word accepted: queue its expected result
			if (sample_valid && !sample_stall) begin
				expected_words.push_back(predict_tap(sample));
			end
			// register write takes effect from the next sample
			if (cfg_valid && cfg_ready) begin
				case (atd_cfg_idx_t'(cfg_index))
					CFG_ENABLE:     en_q = cfg_data[0];
					CFG_THRESHOLD:  thresh_q = cfg_data[JERK_W-1:0];
					CFG_REFRACTORY: refract_q = cfg_data[MS_W-1:0];
					CFG_SETTLE:     settle_q = cfg_data[MS_W-1:0];
					default: ;
				endcase
			end
			// result word accepted: compare with the oldest expectation
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word: tap=%0d jerk=%0d", result.tap,
						result.jerk);
					mismatches++;
				end else begin
					exp_word = expected_words.pop_front();
					if (result.tap !== exp_word.tap) begin
						$error("tap mismatch: expected %0d, got %0d", exp_word.tap,
							result.tap);
						mismatches++;
					end
					if (result.jerk !== exp_word.jerk) begin
						$error("jerk mismatch: expected %0d, got %0d", exp_word.jerk,
							result.jerk);
						mismatches++;
					end
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

FILE: tb/tb_accel_tap_detector.sv
// ----------------------------------------------------------------------------
// tb_accel_tap_detector: testbench for the accelerometer tap detector
// Directed samples walk the settle, refractory and threshold edges across a
// timestamp wrap, then random phases of sensor-like streams run under several
// register settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_accel_tap_detector;
	import atd_pkg::*;

	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 150;
	localparam int HOLD_AFTER   = 60;
	localparam int HOLD_CYCLES  = 150;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	atd_sample_t           sample;
	logic                  result_valid;
	logic                  result_stall;
	atd_result_t           result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned mismatches;
	int unsigned pending;

	// sender state
	int          cur_x, cur_y, cur_z;
	logic [31:0] now_ms;
	int unsigned burst_left;
	int unsigned words_sent;

	accel_tap_detector u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	atd_tap_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int clamp16(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// next axis reading: small drift, now and then a sharp knock
	function automatic int wander(int c);
		int step;
		if ($urandom_range(0, 9) == 0) step = $urandom_range(200, 20000);
		else step = $urandom_range(0, 40);
		if ($urandom_range(0, 1) == 0) step = -step;
		return clamp16(c + step);
	endfunction

	// offers one sample word, inserting random gaps between bursts
	task automatic send_sample(input int x, input int y, input int z,
		input logic [31:0] t);
		atd_sample_t w;
		int unsigned gap;
		w.accel_x = x[15:0];
		w.accel_y = y[15:0];
		w.accel_z = z[15:0];
		w.time_ms = t;
		cur_x  = x;
		cur_y  = y;
		cur_z  = z;
		now_ms = t;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample       <= w;
		do @(posedge clk); while (sample_stall);
		words_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering and let every expected word come out
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: stall patterns, plus one long hold-off while input keeps coming
	initial begin
		int unsigned mode;
		int unsigned len;
		bit          held;
		result_stall = 1'b0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && words_sent >= HOLD_AFTER) begin
				held = 1'b1;
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(10, 60);
			for (int i = 0; i < len; i++) begin
				@(negedge clk);
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 1) == 0);
					2: result_stall <= (i % 3 == 0);
					default: result_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [31:0] t0;
		int          r, x, y, z;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		burst_left   = 0;
		words_sent   = 0;
		cur_x = 0;
		cur_y = 0;
		cur_z = 0;
		now_ms = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default registers; first sample sits just before the timestamp wrap
		t0 = 32'hFFFF_FF00;
		send_sample(0, 0, 0, t0);
		send_sample(32767, 32767, 32767, t0 + 100);
		send_sample(-32768, -32768, -32768, t0 + 200);      // largest jerk, settling
		send_sample(32767, -32768, 0, t0 + 749);            // last settling ms
		send_sample(-32768, -32768, 0, t0 + 750);           // window over: tap
		send_sample(0, 0, 0, t0 + 751);                     // refractory
		send_sample(32767, 0, 0, t0 + 1149);                // last refractory ms
		send_sample(-32768, 0, 0, t0 + 1150);               // tap again
		send_sample(-31569, 0, 0, t0 + 3000);               // one below threshold
		send_sample(-30369, 0, 0, t0 + 3001);               // exactly threshold
		send_sample(-30369, 0, 1, t0 + 3002);
		send_sample(-30369, 0, 1, t0 + 3002);               // no change, same time
		drain();

		// zero threshold and refractory: every sample taps, even jerk zero
		write_reg(CFG_THRESHOLD, '0);
		write_reg(CFG_REFRACTORY, {2'b11, 16'd0});
		end_writes();
		send_sample(-30369, 0, 1, t0 + 3002);
		send_sample(-30369, 0, 1, t0 + 3002);
		drain();

		// disabled: sample gives a zero result word and leaves the history untouched; unused index ignored
		write_reg(CFG_ENABLE, 18'h2);
		write_reg(CFG_UNUSED, '1);
		end_writes();
		send_sample(32767, 32767, 32767, t0 + 3100);
		drain();

		// threshold at the largest possible jerk, refractory and settle at their top values
		write_reg(CFG_ENABLE, 18'h1);
		write_reg(CFG_THRESHOLD, 18'd196605);
		write_reg(CFG_REFRACTORY, 18'd65535);
		write_reg(CFG_SETTLE, 18'd65535);
		end_writes();
		send_sample(-32768, -32768, -32768, t0 + 3200);
		send_sample(32767, 32767, 32767, t0 + 3300);        // settling again
		send_sample(-32768, -32768, -32768, t0 + 70000);
		send_sample(32767, 32767, 32767, t0 + 135534);      // refractory
		send_sample(-32768, -32768, -32768, t0 + 135535);
		drain();

		// random phases
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					write_reg(CFG_THRESHOLD, 18'd1500);
					write_reg(CFG_REFRACTORY, 18'd200);
					write_reg(CFG_SETTLE, '0);
				end
				1: begin
					write_reg(CFG_THRESHOLD, '0);
					write_reg(CFG_REFRACTORY, '0);
				end
				2: begin
					write_reg(CFG_THRESHOLD, 18'd196605);
					write_reg(CFG_REFRACTORY, 18'd65535);
				end
				3: write_reg(CFG_ENABLE, '0);
				4: begin
					write_reg(CFG_ENABLE, 18'h1);
					write_reg(CFG_THRESHOLD, 18'($urandom_range(300, 4000)));
					write_reg(CFG_REFRACTORY, 18'($urandom_range(0, 600)));
					write_reg(CFG_SETTLE, 18'd65535);
				end
				5: begin
					write_reg(CFG_THRESHOLD, 18'd800);
					write_reg(CFG_REFRACTORY, 18'd50);
					write_reg(CFG_SETTLE, 18'($urandom_range(0, 65535)));
				end
				default: begin
					write_reg(CFG_THRESHOLD, 18'($urandom_range(0, 196605)));
					write_reg(CFG_REFRACTORY, 18'($urandom_range(0, 65535)));
				end
			endcase
			end_writes();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 85) begin
					x = wander(cur_x);
					y = wander(cur_y);
					z = wander(cur_z);
					send_sample(x, y, z, now_ms + $urandom_range(0, 40));
				end else if (r < 92) begin
					x = $urandom_range(0, 65535) - 32768;
					y = $urandom_range(0, 65535) - 32768;
					z = $urandom_range(0, 65535) - 32768;
					send_sample(x, y, z, now_ms + $urandom_range(0, 40));
				end else if (r < 96) begin
					// full-scale flip on every axis
					x = (cur_x < 0) ? 32767 : -32768;
					y = (cur_y < 0) ? 32767 : -32768;
					z = (cur_z < 0) ? 32767 : -32768;
					send_sample(x, y, z, now_ms + $urandom_range(0, 400));
				end else begin
					x = $urandom_range(0, 65535) - 32768;
					y = $urandom_range(0, 65535) - 32768;
					z = $urandom_range(0, 65535) - 32768;
					send_sample(x, y, z, $urandom);
				end
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
